FILE: rtl/sprq_pkg.sv
// Package: table sizes, status codes and record type for the price range query core.
`default_nettype none
package sprq_pkg;
    localparam int Capacity = 32;
    localparam int AddrW = $clog2(Capacity);
    localparam int CountW = $clog2(Capacity + 1);

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_MATCH    = 3'd2;
    localparam logic [2:0] ST_NO_MATCH = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] stock;
        logic [15:0] price;
    } t_rec;
endpackage
`default_nettype wire

FILE: rtl/sorted_price_range_query_core.sv
// Top level: sorted product table with ordered insert and price range query.
//
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+----------------------------------------------
// in      | input     | i_valid / o_ready    | opcode, product_id, stock_count, price, min/max
// out     | output    | o_valid / i_ready    | status, out_product, out_stock, out_price, last
//
// Flow: an insert moves each record priced above the new one up by one slot, walking
// down from the top, places the new record, then sends its response beat. A query
// walks the table through the single read port, one entry per cycle unless a second
// match waits on a stalled output, then sends the response.
// Each match is held until the next one is found, so the final beat carries last.
// Reset clears the record count and control; table contents stay undefined.
// A stalled output holds the walk only when a second match is waiting; a new input
// beat is taken whenever the core is idle, even with a result beat still pending.
`default_nettype none
module sorted_price_range_query_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_product_id,
    input  wire logic [15:0] i_stock_count,
    input  wire logic [15:0] i_price,
    input  wire logic [15:0] i_min_price,
    input  wire logic [15:0] i_max_price,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_out_product,
    output logic [15:0]      o_out_stock,
    output logic [15:0]      o_out_price,
    output logic             o_last
);
    typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_QUERY, S_RESP} t_state;

    localparam int AW = sprq_pkg::AddrW;
    localparam int CW = sprq_pkg::CountW;

    sprq_pkg::t_rec r_mem [sprq_pkg::Capacity];
    sprq_pkg::t_rec r_rd;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;      // shift: slot being filled; query: next read address
    logic            r_rd_vld;   // r_rd holds a fetched entry not yet consumed
    sprq_pkg::t_rec  r_pend;     // latest match, held until its successor is known
    logic            r_pend_vld;
    logic [2:0]      r_code;     // status of the closing beat when no match is held
    sprq_pkg::t_rec  r_new;
    logic [15:0]     r_lo, r_hi;
    logic [2:0]      r_status;
    logic [15:0]     r_oid, r_ost, r_opr;
    logic            r_last, r_oval;

    // memory controls
    logic            mem_we;
    logic [AW-1:0]   mem_wa, mem_ra;
    sprq_pkg::t_rec  mem_wd;
    logic            mem_re;

    // output register load
    logic            emit;
    logic [2:0]      emit_status;
    sprq_pkg::t_rec  emit_rec;
    logic            emit_last;

    logic out_free;
    assign out_free = !r_oval || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    logic in_fire;
    assign in_fire = i_valid && o_ready;

    logic rd_match;
    assign rd_match = (r_rd.price >= r_lo) && (r_rd.price <= r_hi);

    // Consume the fetched entry unless it is a match that must wait for the held one.
    logic rd_take;
    assign rd_take = r_rd_vld && (!rd_match || !r_pend_vld || out_free);

    // Shift phase: r_idx is the slot to fill; read slot r_idx-1 ahead into r_rd.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_idx[AW-1:0];
        mem_wd = r_new;
        mem_re = 1'b0;
        mem_ra = r_idx[AW-1:0] - AW'(1);
        case (r_state)
            S_SHIFT: begin
                if (r_idx == '0) begin
                    mem_we = 1'b1;
                end else if (r_rd_vld) begin
                    mem_we = 1'b1;
                    if (r_rd.price > r_new.price) begin
                        mem_wd = r_rd;
                        mem_re = (r_idx > CW'(1));
                        mem_ra = r_idx[AW-1:0] - AW'(2);
                    end
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_QUERY: begin
                mem_ra = r_idx[AW-1:0];
                mem_re = (r_idx < r_count) && (!r_rd_vld || rd_take);
            end
            default: ;
        endcase
    end

    // Release the held match when a newer one arrives; close with last in the response.
    always_comb begin
        emit        = 1'b0;
        emit_status = r_code;
        emit_rec    = '0;
        emit_last   = 1'b1;
        case (r_state)
            S_QUERY: begin
                if (rd_take && rd_match && r_pend_vld) begin
                    emit        = 1'b1;
                    emit_status = sprq_pkg::ST_MATCH;
                    emit_rec    = r_pend;
                    emit_last   = 1'b0;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (r_pend_vld) begin
                        emit_status = sprq_pkg::ST_MATCH;
                        emit_rec    = r_pend;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_oval     <= 1'b0;
        end else begin
            if (emit) begin
                r_oval   <= 1'b1;
                r_status <= emit_status;
                r_oid    <= emit_rec.id;
                r_ost    <= emit_rec.stock;
                r_opr    <= emit_rec.price;
                r_last   <= emit_last;
            end else if (r_oval && i_ready) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_new <= '{i_product_id, i_stock_count, i_price};
                        r_lo  <= i_min_price;
                        r_hi  <= i_max_price;
                        r_rd_vld   <= 1'b0;
                        r_pend_vld <= 1'b0;
                        r_idx <= (i_opcode == sprq_pkg::OP_INSERT) ? r_count : '0;
                        if (i_opcode == sprq_pkg::OP_INSERT) begin
                            if (r_count >= CW'(sprq_pkg::Capacity)) begin
                                r_code  <= sprq_pkg::ST_FULL;
                                r_state <= S_RESP;
                            end else begin
                                r_state <= S_SHIFT;
                            end
                        end else if (i_min_price > i_max_price || r_count == '0) begin
                            r_code  <= sprq_pkg::ST_INVALID;
                            r_state <= S_RESP;
                        end else begin
                            r_code  <= sprq_pkg::ST_NO_MATCH;
                            r_state <= S_QUERY;
                        end
                    end
                end
                S_SHIFT: begin
                    if (r_idx == '0 || (r_rd_vld && !(r_rd.price > r_new.price))) begin
                        // new record placed; done
                        r_count <= r_count + CW'(1);
                        r_code  <= sprq_pkg::ST_INSERTED;
                        r_state <= S_RESP;
                    end else if (r_rd_vld) begin
                        // moved entry up; advance down
                        r_idx    <= r_idx - CW'(1);
                        r_rd_vld <= (r_idx > CW'(1));
                    end else begin
                        r_rd_vld <= 1'b1;
                    end
                end
                S_QUERY: begin
                    if (rd_take && rd_match) begin
                        r_pend     <= r_rd;
                        r_pend_vld <= 1'b1;
                    end
                    if (!r_rd_vld || rd_take) begin
                        r_rd_vld <= mem_re;
                        if (mem_re) r_idx <= r_idx + CW'(1);
                        // walk finished once nothing is left to fetch or consume
                        if (!mem_re) r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_oval;
    assign o_status      = r_status;
    assign o_out_product = r_oid;
    assign o_out_stock   = r_ost;
    assign o_out_price   = r_opr;
    assign o_last        = r_last;

    ap_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(sprq_pkg::Capacity))
        else $error("record count beyond capacity");
    ap_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("input accepted while busy");
    ap_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + CW'(1)))
        else $error("record count jumped");
endmodule
`default_nettype wire

FILE: tb/sorted_price_range_query_core_tb.sv
// Testbench for the sorted price range query core: ordered inserts and range queries.
`timescale 1ns / 1ps
`default_nettype none
module sorted_price_range_query_core_tb;

    // One result beat as the block should present it.
    typedef struct {
        logic [2:0]  status;
        logic [15:0] product;
        logic [15:0] stock;
        logic [15:0] price;
        logic        last;
    } t_beat;

    // Scoreboard: keeps its own ordered copy of the table and the beats still owed.
    class price_table_sb;
        sprq_pkg::t_rec recs[$];
        t_beat          owed[$];
        int unsigned    n_match_beats;
        int unsigned    n_full;
        int unsigned    n_beats_seen;
        int unsigned    n_errors;

        task report_mismatch(input string what, input logic [15:0] got,
                             input logic [15:0] want);
            $display("tb: mismatch on %s: got %0h, want %0h", what, got, want);
            n_errors++;
        endtask

        function void note_item(logic op, logic [15:0] id, logic [15:0] stock,
                                logic [15:0] price, logic [15:0] lo, logic [15:0] hi);
            t_beat          b;
            sprq_pkg::t_rec r;
            int             pos;
            int             hits;
            b = '{sprq_pkg::ST_INSERTED, 16'd0, 16'd0, 16'd0, 1'b1};
            if (op == sprq_pkg::OP_INSERT) begin
                if (recs.size() >= sprq_pkg::Capacity) begin
                    b.status = sprq_pkg::ST_FULL;
                    n_full++;
                end else begin
                    // stable: land after every record whose price is not greater
                    pos = recs.size();
                    while (pos > 0 && recs[pos-1].price > price) pos--;
                    r.id = id;
                    r.stock = stock;
                    r.price = price;
                    recs.insert(pos, r);
                end
                owed.push_back(b);
            end else if (lo > hi || recs.size() == 0) begin
                b.status = sprq_pkg::ST_INVALID;
                owed.push_back(b);
            end else begin
                hits = 0;
                foreach (recs[i]) begin
                    if (recs[i].price >= lo && recs[i].price <= hi) begin
                        owed.push_back('{sprq_pkg::ST_MATCH, recs[i].id, recs[i].stock,
                                         recs[i].price, 1'b0});
                        hits++;
                    end
                end
                if (hits == 0) begin
                    b.status = sprq_pkg::ST_NO_MATCH;
                    owed.push_back(b);
                end else begin
                    owed[$].last = 1'b1;
                    n_match_beats += hits;
                end
            end
        endfunction

        task check_beat(input logic [2:0] st, input logic [15:0] pr, input logic [15:0] sk,
                        input logic [15:0] pc, input logic lst);
            t_beat w;
            n_beats_seen++;
            if (owed.size() == 0) begin
                report_mismatch("unexpected beat status", 16'(st), 16'hxxxx);
                return;
            end
            w = owed.pop_front();
            if (st  !== w.status)  report_mismatch("status", 16'(st), 16'(w.status));
            if (pr  !== w.product) report_mismatch("product", pr, w.product);
            if (sk  !== w.stock)   report_mismatch("stock", sk, w.stock);
            if (pc  !== w.price)   report_mismatch("price", pc, w.price);
            if (lst !== w.last)    report_mismatch("last", 16'(lst), 16'(w.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = sprq_pkg::OP_INSERT;
    logic [15:0] prod_id = '0, stock_cnt = '0, rec_price = '0, lo_price = '0, hi_price = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  out_status;
    logic [15:0] out_product, out_stock, out_price;
    logic        out_last;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_price_range_query_core u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_opcode(op), .i_product_id(prod_id), .i_stock_count(stock_cnt),
        .i_price(rec_price), .i_min_price(lo_price), .i_max_price(hi_price),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_status(out_status), .o_out_product(out_product), .o_out_stock(out_stock),
        .o_out_price(out_price), .o_last(out_last)
    );

    price_table_sb sb = new();

    bit quiet_tail = 0;     // no idling on either side near the end
    bit hold_sink = 0;      // receiver held off for a long stretch
    int unsigned n_items = 0;
    int unsigned n_queries = 0;

    // Check every accepted result beat, using the values present at the taking edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(out_status, out_product, out_stock, out_price, out_last);
    end

    // Receiver: random stalls in bursts, a long hold-off on request, none in the tail.
    initial begin : sink
        int gap;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_sink) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_sink = 0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 7);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: stop if no beat moves on either side for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
            else idle++;
            if (idle >= 5000) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Offer one item and hold it until accepted, with an optional idle burst first.
    task automatic send_item(input logic o, input logic [15:0] id, input logic [15:0] sk,
                             input logic [15:0] pr, input logic [15:0] lo,
                             input logic [15:0] hi);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        prod_id   <= id;
        stock_cnt <= sk;
        rec_price <= pr;
        lo_price  <= lo;
        hi_price  <= hi;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(o, id, sk, pr, lo, hi);
        n_items++;
        if (o == sprq_pkg::OP_QUERY) n_queries++;
    endtask

    task automatic send_insert(input logic [15:0] id, input logic [15:0] sk,
                               input logic [15:0] pr);
        send_item(sprq_pkg::OP_INSERT, id, sk, pr, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_query(input logic [15:0] lo, input logic [15:0] hi);
        send_item(sprq_pkg::OP_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), lo, hi);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0) @(posedge clk);
    endtask

    // Mix inserts and range queries, with prices drawn from a narrow band so ties and spans are common.
    task automatic random_session(input int n_ins, input int n_q);
        int base;
        base = $urandom_range(0, 1) ? $urandom_range(0, 65535 - 64) : 0;
        for (int i = 0; i < n_ins + n_q; i++) begin
            if ($urandom_range(0, n_ins + n_q - 1) < n_ins)
                send_insert(16'($urandom), 16'($urandom), 16'(base + $urandom_range(0, 63)));
            else if ($urandom_range(0, 9) == 0)
                send_query(16'($urandom), 16'($urandom)); // noise, often invalid
            else begin
                int a, b;
                a = base + $urandom_range(0, 63);
                b = a + $urandom_range(0, 40);
                if (b > 65535) b = 65535;
                send_query(16'(a), 16'(b));
            end
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, ties, bounds.
        send_query(16'd0, 16'hffff);                       // empty table
        send_insert(16'hffff, 16'hffff, 16'hffff);
        send_insert(16'h0000, 16'h0000, 16'h0000);
        send_insert(16'h1234, 16'h0001, 16'h0100);
        send_insert(16'h5678, 16'h0002, 16'h0100);         // tie keeps insertion order
        send_insert(16'haaaa, 16'h5555, 16'h8000);
        send_query(16'd0, 16'hffff);                       // whole table
        send_query(16'h0100, 16'h0100);                    // both ties
        send_query(16'h0101, 16'h7fff);                    // no match
        send_query(16'h0200, 16'h0100);                    // min above max
        send_query(16'hffff, 16'hffff);
        send_query(16'h0000, 16'h0000);
        send_insert(16'h5555, 16'haaaa, 16'h7fff);
        // Fill to capacity and probe the full case.
        while (sb.recs.size() < sprq_pkg::Capacity)
            send_insert(16'($urandom), 16'($urandom), 16'($urandom));
        send_insert(16'h0001, 16'h0001, 16'h0001);         // table full
        send_query(16'd0, 16'hffff);                       // longest answer

        // Long receiver hold-off while the sender keeps going.
        hold_sink = 1;
        for (int i = 0; i < 6; i++) send_query(16'd0, 16'hffff);
        drain;                                             // sender waits for all results

        // Random part: fresh tables through reset-free phases are not possible,
        // so reuse the full table for queries, then keep going with full inserts.
        random_session(10, 60);
        drain;
        quiet_tail = 1;
        random_session(10, 80);
        drain;
        repeat (50) @(posedge clk);

        $display("tb: %0d items, %0d queries, %0d match beats, %0d table-full answers",
                 n_items, n_queries, sb.n_match_beats, sb.n_full);
        $display("tb: %0d result beats checked, %0d mismatches",
                 sb.n_beats_seen, sb.n_errors);
        if (sb.n_errors == 0 && sb.owed.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
